@@ src/pedal_plausibility_torque_command_assert.svh @@
// ----------------------------------------------------------------------------
// Pedal plausibility torque command: assertion macros
// Shared concurrent assertion forms, clocked and reset-qualified.
// ----------------------------------------------------------------------------
`ifndef PEDAL_PLAUSIBILITY_TORQUE_COMMAND_ASSERT_SVH
`define PEDAL_PLAUSIBILITY_TORQUE_COMMAND_ASSERT_SVH

// Same-cycle implication: when ante holds, cons must hold.
`define PPTC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pptc: same-cycle check failed");

// Next-cycle implication: when ante holds, cons must hold in the next cycle.
`define PPTC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pptc: next-cycle check failed");

`endif

@@ src/pptc_pkg.sv @@
// ----------------------------------------------------------------------------
// Pedal plausibility torque command: package
// Shared types, register codes, status codes and fixed constants.
// ----------------------------------------------------------------------------
package pptc_pkg;

    // Default parameter values.
    localparam int ADC_BITS_DEF   = 12;
    localparam int TORQUE_MAX_DEF = 700;

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int LEVEL_W    = 12;
    localparam int RPM_W      = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_BRAKE_ACTIVE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_THROTTLE_ACTIVE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LATCH_RELEASE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MISMATCH_LIMIT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DISCONNECT      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED_CAP       = 3'd5;

    // Register reset values.
    localparam int RST_BRAKE_ACTIVE    = 850;
    localparam int RST_THROTTLE_ACTIVE = 300;
    localparam int RST_LATCH_RELEASE   = 200;
    localparam int RST_MISMATCH_LIMIT  = 2000;
    localparam int RST_DISCONNECT      = 4050;
    localparam int RST_SPEED_CAP       = 9000;

    // Status codes.
    typedef logic [2:0] t_status;
    localparam t_status ST_NORMAL      = 3'd0;
    localparam t_status ST_DISCONNECT  = 3'd1;
    localparam t_status ST_MISMATCH    = 3'd2;
    localparam t_status ST_RANGE       = 3'd3;
    localparam t_status ST_IMPLAUSIBLE = 3'd4;
    localparam t_status ST_BRAKING     = 3'd5;

    // Sensor calibration.
    localparam int R_OFFSET   = 1600;
    localparam int L_OFFSET   = 2900;
    localparam int R_FULL     = 2600;
    localparam int L_FULL     = 3800;
    localparam int RANGE_HIGH = 4000;
    localparam int RANGE_LOW  = 500;
    localparam int PEDAL_SPAN = (R_FULL + L_FULL - R_OFFSET - L_OFFSET) / 2;

    // A normal sample has both readings at or below RANGE_HIGH, so the pedal
    // value stays below 2^11.
    localparam int PEDAL_W = 11;

    // Power cap: floor(POWER_NUM / (POWER_DEN * rpm)).
    localparam int POWER_NUM = 40000000;
    localparam int POWER_DEN = 105;

    // Bit-serial divider length: wide enough for POWER_NUM and pedal*TORQUE_MAX.
    localparam int DIV_BITS = 26;

endpackage

@@ src/pptc_sample_if.sv @@
// ----------------------------------------------------------------------------
// Pedal plausibility torque command: sample channel
// Valid/ready channel carrying one pedal and speed sample.
// ----------------------------------------------------------------------------
interface pptc_sample_if #(
    parameter int ADC_BITS = 12
);
    import pptc_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [ADC_BITS-1:0]  apps_right;
    logic [ADC_BITS-1:0]  apps_left;
    logic [ADC_BITS-1:0]  brake_sensor;
    logic [RPM_W-1:0]     motor_rpm;

    modport source (
        output valid, apps_right, apps_left, brake_sensor, motor_rpm,
        input  ready
    );

    modport sink (
        input  valid, apps_right, apps_left, brake_sensor, motor_rpm,
        output ready
    );

endinterface

@@ src/pptc_result_if.sv @@
// ----------------------------------------------------------------------------
// Pedal plausibility torque command: result channel
// Valid/ready channel carrying one torque command and its status.
// ----------------------------------------------------------------------------
interface pptc_result_if #(
    parameter int TORQUE_W = 10
);
    import pptc_pkg::*;

    logic                valid;
    logic                ready;
    logic [TORQUE_W-1:0] torque;
    t_status             status;
    logic                fault;
    logic                implausible_latched;

    modport source (
        output valid, torque, status, fault, implausible_latched,
        input  ready
    );

    modport sink (
        input  valid, torque, status, fault, implausible_latched,
        output ready
    );

endinterface

@@ src/pedal_plausibility_torque_command.sv @@
// ----------------------------------------------------------------------------
// Pedal plausibility torque command
// Classifies pedal samples, keeps the brake/throttle implausibility latch
// and computes the motor torque command with a bit-serial divider.
// ----------------------------------------------------------------------------
// Usage:
// Samples arrive on i_sample, a valid/ready channel; each transaction carries
// both accelerator readings, the brake reading and the motor speed. Every
// sample produces exactly one transaction on o_result: torque, status code,
// fault flag and the latch value after that sample.
// Classification and the latch update happen at the accepting edge. The
// torque then goes through a multiply state and a 26-step restoring
// divider that computes the pedal map and the power cap side by side, one
// quotient bit per cycle. The block takes no new sample until the result
// of the last one has been loaded into the output register.
// The result sits in an output register, so a new sample is accepted while a
// finished result waits; if the receiver stalls longer, the finished result
// of the next sample is held in the core until the output register frees.
// Reset (synchronous, active low) clears the latch, empties the pipeline and
// loads the register defaults. Configuration writes on i_cfg_* take effect
// at the next edge and are meant to be issued only while the block is idle.
// ----------------------------------------------------------------------------
`include "pedal_plausibility_torque_command_assert.svh"

module pedal_plausibility_torque_command #(
    parameter int ADC_BITS   = pptc_pkg::ADC_BITS_DEF,
    parameter int TORQUE_MAX = pptc_pkg::TORQUE_MAX_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [pptc_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [pptc_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    pptc_sample_if.sink                      i_sample,
    pptc_result_if.source                    o_result
);
    import pptc_pkg::*;

    // Internal widths. AW covers both the readings and the 12-bit constants;
    // CW holds signed sums and differences of offset readings.
    localparam int AW       = (ADC_BITS > LEVEL_W) ? ADC_BITS : LEVEL_W;
    localparam int CW       = AW + 2;
    localparam int TW       = $clog2(TORQUE_MAX + 1);
    localparam int MDW      = $clog2(PEDAL_SPAN + 1);
    localparam int MRW      = MDW + 1;
    localparam int CDW      = RPM_W + $clog2(POWER_DEN + 1);
    localparam int CRW      = CDW + 1;
    localparam int CNT_W    = $clog2(DIV_BITS);

    localparam logic [DIV_BITS-1:0] C_POWER_NUM = DIV_BITS'(POWER_NUM);
    localparam logic signed [CW-1:0] C_R_OFF    = CW'(R_OFFSET);
    localparam logic signed [CW-1:0] C_L_OFF    = CW'(L_OFFSET);

    // Sequencer states.
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_MUL  = 2'd1;
    localparam logic [1:0] S_DIV  = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    // Configuration registers.
    logic [LEVEL_W-1:0]        r_cfg_brake;
    logic signed [LEVEL_W-1:0] r_cfg_throttle;
    logic signed [LEVEL_W-1:0] r_cfg_release;
    logic [LEVEL_W-1:0]        r_cfg_mismatch;
    logic [LEVEL_W-1:0]        r_cfg_disc;
    logic [RPM_W-1:0]          r_cfg_speed;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_brake    <= LEVEL_W'(RST_BRAKE_ACTIVE);
            r_cfg_throttle <= LEVEL_W'(RST_THROTTLE_ACTIVE);
            r_cfg_release  <= LEVEL_W'(RST_LATCH_RELEASE);
            r_cfg_mismatch <= LEVEL_W'(RST_MISMATCH_LIMIT);
            r_cfg_disc     <= LEVEL_W'(RST_DISCONNECT);
            r_cfg_speed    <= RPM_W'(RST_SPEED_CAP);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_BRAKE_ACTIVE:    r_cfg_brake    <= i_cfg_data[LEVEL_W-1:0];
                CFG_THROTTLE_ACTIVE: r_cfg_throttle <= i_cfg_data[LEVEL_W-1:0];
                CFG_LATCH_RELEASE:   r_cfg_release  <= i_cfg_data[LEVEL_W-1:0];
                CFG_MISMATCH_LIMIT:  r_cfg_mismatch <= i_cfg_data[LEVEL_W-1:0];
                CFG_DISCONNECT:      r_cfg_disc     <= i_cfg_data[LEVEL_W-1:0];
                CFG_SPEED_CAP:       r_cfg_speed    <= i_cfg_data[RPM_W-1:0];
                default: ;
            endcase
        end
    end

    // Control and payload registers.
    logic [1:0]          r_state;
    logic [CNT_W-1:0]    r_cnt;
    logic                r_latch;
    t_status             r_status;
    logic                r_use_map;
    logic                r_cap_en;
    logic [PEDAL_W-1:0]  r_pedal;
    logic [RPM_W-1:0]    r_rpm;

    logic [DIV_BITS-1:0] r_map_num;
    logic [MRW-1:0]      r_map_rem;
    logic [DIV_BITS-1:0] r_map_quo;
    logic [DIV_BITS-1:0] r_cap_num;
    logic [CDW-1:0]      r_cap_den;
    logic [CRW-1:0]      r_cap_rem;
    logic [DIV_BITS-1:0] r_cap_quo;

    logic                r_out_valid;
    logic [TW-1:0]       r_out_torque;
    t_status             r_out_status;
    logic                r_out_fault;
    logic                r_out_latch;

    logic accept;
    logic out_free;
    assign i_sample.ready = (r_state == S_IDLE);
    assign accept         = i_sample.valid && i_sample.ready;
    assign out_free       = !r_out_valid || o_result.ready;

    // Sample classification. All comparisons run on the accepting cycle.
    logic [AW-1:0]        r_ext, l_ext, b_ext;
    logic signed [CW-1:0] dr, dl, sum, pedal, diff;
    logic [CW-1:0]        diff_abs;
    logic                 is_disc, is_mismatch, is_range, is_brake, is_throttle;
    t_status              n_status;
    logic                 latch_set;
    logic                 n_latch;

    always_comb begin
        r_ext = AW'(i_sample.apps_right);
        l_ext = AW'(i_sample.apps_left);
        b_ext = AW'(i_sample.brake_sensor);
        dr    = $signed({2'b00, r_ext}) - C_R_OFF;
        dl    = $signed({2'b00, l_ext}) - C_L_OFF;
        sum   = dr + dl;
        // Halve with rounding toward zero.
        pedal = (sum + $signed({{(CW-1){1'b0}}, sum[CW-1]})) >>> 1;
        diff  = dr - dl;
        diff_abs = diff[CW-1] ? CW'(-diff) : CW'(diff);

        is_disc = (r_ext > AW'(r_cfg_disc)) || (l_ext > AW'(r_cfg_disc))
               || (b_ext > AW'(r_cfg_disc));
        is_mismatch = diff_abs > CW'(r_cfg_mismatch);
        is_range = (r_ext > AW'(RANGE_HIGH)) || (l_ext > AW'(RANGE_HIGH))
                || (b_ext > AW'(RANGE_HIGH)) || (r_ext < AW'(RANGE_LOW))
                || (l_ext < AW'(RANGE_LOW));
        is_brake    = b_ext > AW'(r_cfg_brake);
        is_throttle = pedal > CW'(r_cfg_throttle);

        latch_set = 1'b0;
        if (is_disc) begin
            n_status = ST_DISCONNECT;
        end else if (is_mismatch) begin
            n_status = ST_MISMATCH;
        end else if (is_range) begin
            n_status = ST_RANGE;
        end else if (is_brake) begin
            if (is_throttle) begin
                n_status  = ST_IMPLAUSIBLE;
                latch_set = 1'b1;
            end else begin
                n_status = ST_BRAKING;
            end
        end else begin
            n_status = ST_NORMAL;
        end

        // The release check sees the latch after this sample may have set it.
        n_latch = r_latch || latch_set;
        if (n_latch && (pedal < CW'(r_cfg_release))) begin
            n_latch = 1'b0;
        end
    end

    // One restoring-division step for each of the two dividers.
    logic [MRW-1:0] map_trial;
    logic           map_ge;
    logic [CRW-1:0] cap_trial;
    logic           cap_ge;

    always_comb begin
        map_trial = {r_map_rem[MRW-2:0], r_map_num[DIV_BITS-1]};
        map_ge    = map_trial >= MRW'(PEDAL_SPAN);
        cap_trial = {r_cap_rem[CRW-2:0], r_cap_num[DIV_BITS-1]};
        cap_ge    = cap_trial >= CRW'(r_cap_den);
    end

    // Final torque: clamp the mapped value, apply the power cap, and force zero unless the map is in use.
    logic [TW-1:0] map_sat;
    logic [TW-1:0] n_torque;

    always_comb begin
        map_sat = (r_map_quo > DIV_BITS'(TORQUE_MAX)) ? TW'(TORQUE_MAX)
                                                      : r_map_quo[TW-1:0];
        n_torque = map_sat;
        if (r_cap_en && (r_cap_quo < DIV_BITS'(map_sat))) begin
            n_torque = r_cap_quo[TW-1:0];
        end
        if (!r_use_map) begin
            n_torque = '0;
        end
    end

    // Sequencer and datapath.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_latch <= 1'b0;
            r_cnt   <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_latch <= n_latch;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_cnt   <= CNT_W'(DIV_BITS - 1);
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (r_cnt == '0) begin
                        r_state <= S_DONE;
                    end else begin
                        r_cnt <= r_cnt - 1'b1;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_status  <= n_status;
            r_use_map <= (n_status == ST_NORMAL) && !r_latch;
            r_cap_en  <= (i_sample.motor_rpm >= r_cfg_speed)
                      && (i_sample.motor_rpm != '0);
            r_pedal   <= pedal[CW-1] ? '0 : pedal[PEDAL_W-1:0];
            r_rpm     <= i_sample.motor_rpm;
        end
        if (r_state == S_MUL) begin
            r_map_num <= DIV_BITS'(r_pedal) * DIV_BITS'(TORQUE_MAX);
            r_cap_den <= CDW'(r_rpm) * CDW'(POWER_DEN);
            r_cap_num <= C_POWER_NUM;
            r_map_rem <= '0;
            r_cap_rem <= '0;
            r_map_quo <= '0;
            r_cap_quo <= '0;
        end
        if (r_state == S_DIV) begin
            r_map_num <= {r_map_num[DIV_BITS-2:0], 1'b0};
            r_cap_num <= {r_cap_num[DIV_BITS-2:0], 1'b0};
            r_map_rem <= map_ge ? (map_trial - MRW'(PEDAL_SPAN)) : map_trial;
            r_cap_rem <= cap_ge ? (cap_trial - CRW'(r_cap_den)) : cap_trial;
            r_map_quo <= {r_map_quo[DIV_BITS-2:0], map_ge};
            r_cap_quo <= {r_cap_quo[DIV_BITS-2:0], cap_ge};
        end
    end

    // Output register.
    logic load_out;
    assign load_out = (r_state == S_DONE) && out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_torque <= n_torque;
            r_out_status <= r_status;
            r_out_fault  <= (r_status == ST_DISCONNECT) || (r_status == ST_MISMATCH)
                         || (r_status == ST_RANGE);
            r_out_latch  <= r_latch;
        end
    end

    assign o_result.valid               = r_out_valid;
    assign o_result.torque              = r_out_torque;
    assign o_result.status              = r_out_status;
    assign o_result.fault               = r_out_fault;
    assign o_result.implausible_latched = r_out_latch;

    // Checks.
    `PPTC_ASSERT_IMP(a_busy_not_ready, i_clk, i_rst_n,
        r_state != S_IDLE, !i_sample.ready)
    `PPTC_ASSERT_IMP(a_torque_only_normal, i_clk, i_rst_n,
        r_out_valid && (r_out_torque != '0), r_out_status == ST_NORMAL)
    `PPTC_ASSERT_IMP(a_torque_bound, i_clk, i_rst_n,
        r_out_valid, r_out_torque <= TW'(TORQUE_MAX))
    `PPTC_ASSERT_NEXT(a_div_ends, i_clk, i_rst_n,
        (r_state == S_DIV) && (r_cnt == '0), r_state == S_DONE)

endmodule

@@ sim/tb_pedal_plausibility_torque_command.sv @@
// ----------------------------------------------------------------------------
// Pedal plausibility torque command: testbench
// Sends pedal and speed samples through the block under changing level
// settings and random handshake stalls, predicts every torque command
// in-house and compares each returned transaction field by field.
// ----------------------------------------------------------------------------
module tb_pedal_plausibility_torque_command;
    timeunit 1ns;
    timeprecision 1ps;

    import pptc_pkg::*;

    localparam int ADC_W           = ADC_BITS_DEF;
    localparam int TORQUE_W        = 10;
    localparam int TORQUE_LIMIT    = TORQUE_MAX_DEF;
    localparam int ADC_FULL        = (1 << ADC_W) - 1;
    localparam int RPM_FULL        = (1 << RPM_W) - 1;
    localparam int CYCLE_LIMIT     = 300000;
    // Cycles to wait at the end so that a stray extra transaction still shows up.
    localparam int SETTLE_CYCLES   = 60;
    localparam int HOLD_OFF_CYCLES = 400;

    // Register indexes past the last register; writes to them must be ignored.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_FIRST = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LAST  = 3'd7;

    typedef struct packed {
        logic [ADC_W-1:0] apps_right;
        logic [ADC_W-1:0] apps_left;
        logic [ADC_W-1:0] brake_sensor;
        logic [RPM_W-1:0] motor_rpm;
    } t_pedal_sample;

    typedef struct packed {
        logic [TORQUE_W-1:0] torque;
        t_status             status;
        logic                fault;
        logic                latched;
    } t_torque_result;

    // ------------------------------------------------------------------------
    // Clock, reset, configuration port and the two channels.
    // ------------------------------------------------------------------------
    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    pptc_sample_if #(.ADC_BITS(ADC_W))    sample_ch ();
    pptc_result_if #(.TORQUE_W(TORQUE_W)) result_ch ();

    pedal_plausibility_torque_command DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_sample   (sample_ch),
        .o_result   (result_ch)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Shadow copy of the level registers and of the implausibility latch.
    // The shadow registers change only when the block is idle, so the
    // prediction made at acceptance always sees the settings the block uses.
    // ------------------------------------------------------------------------
    int brake_lvl;
    int throttle_lvl;
    int release_lvl;
    int mismatch_lim;
    int disc_lvl;
    int speed_cap;
    bit latch_model;

    t_pedal_sample  pending_samples[$];
    t_torque_result expected_cmds[$];

    // Idle percentages of the sender and the receiver, and a hold-off request
    // for the receiver: the stimulus bumps hold_gen, the monitor notices the
    // change and counts the stall out in its own process.
    int snd_idle_pct = 0;
    int rcv_idle_pct = 0;
    int hold_gen     = 0;
    int hold_ack     = 0;
    int hold_left    = 0;
    int errors       = 0;

    // Works out the torque command for one accepted sample and advances the
    // latch. The classification runs in priority order: broken wire, sensor
    // disagreement, reading out of range, brake with throttle, brake alone.
    function automatic t_torque_result predict_command(t_pedal_sample smp);
        t_torque_result res;
        int r, l, b, rpm;
        int dr, dl, pedal, diff, tq, cap;
        r     = smp.apps_right;
        l     = smp.apps_left;
        b     = smp.brake_sensor;
        rpm   = smp.motor_rpm;
        dr    = r - R_OFFSET;
        dl    = l - L_OFFSET;
        // Integer division in SystemVerilog truncates toward zero, as needed.
        pedal = (dr + dl) / 2;
        diff  = (dr > dl) ? dr - dl : dl - dr;
        tq    = 0;
        if (r > disc_lvl || l > disc_lvl || b > disc_lvl) begin
            res.status = ST_DISCONNECT;
        end else if (diff > mismatch_lim) begin
            res.status = ST_MISMATCH;
        end else if (r > RANGE_HIGH || l > RANGE_HIGH || b > RANGE_HIGH ||
                     r < RANGE_LOW || l < RANGE_LOW) begin
            res.status = ST_RANGE;
        end else if (b > brake_lvl) begin
            if (pedal > throttle_lvl) begin
                latch_model = 1'b1;
                res.status  = ST_IMPLAUSIBLE;
            end else begin
                res.status = ST_BRAKING;
            end
        end else begin
            res.status = ST_NORMAL;
            // A latch that was already set on entry forces zero torque.
            if (!latch_model) begin
                if (pedal > 0) begin
                    tq = pedal * TORQUE_LIMIT / PEDAL_SPAN;
                    if (tq > TORQUE_LIMIT) begin
                        tq = TORQUE_LIMIT;
                    end
                end
                // A threshold of zero with the motor at standstill applies no cap.
                if (rpm >= speed_cap && rpm != 0) begin
                    cap = POWER_NUM / (POWER_DEN * rpm);
                    if (cap < tq) begin
                        tq = cap;
                    end
                end
            end
        end
        // Release is checked after the update, so a latch set by this very
        // sample can clear again before it is reported.
        if (latch_model && pedal < release_lvl) begin
            latch_model = 1'b0;
        end
        res.torque  = tq[TORQUE_W-1:0];
        res.fault   = (res.status == ST_DISCONNECT || res.status == ST_MISMATCH ||
                       res.status == ST_RANGE);
        res.latched = latch_model;
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------------
    function automatic logic [ADC_W-1:0] clamp_adc(int v);
        if (v < 0) begin
            return '0;
        end
        if (v > ADC_FULL) begin
            return ADC_FULL[ADC_W-1:0];
        end
        return v[ADC_W-1:0];
    endfunction

    // A reading right at one of the decision thresholds or one step past it.
    function automatic logic [ADC_W-1:0] boundary_value();
        case ($urandom_range(0, 7))
            0:       return clamp_adc(RANGE_LOW - 1);
            1:       return clamp_adc(RANGE_LOW);
            2:       return clamp_adc(RANGE_HIGH);
            3:       return clamp_adc(RANGE_HIGH + 1);
            4:       return clamp_adc(disc_lvl);
            5:       return clamp_adc(disc_lvl + 1);
            6:       return clamp_adc(brake_lvl);
            default: return clamp_adc(brake_lvl + 1);
        endcase
    endfunction

    // Most samples are well formed: the two pedal sensors track each other,
    // the brake often hovers around its threshold and the speed often sits near the
    // cap threshold. A fifth are pushed onto a threshold, the rest is noise.
    function automatic t_pedal_sample draw_sample();
        t_pedal_sample smp;
        int kind, dr, dl, b, rpm;
        kind = $urandom_range(0, 99);
        dr   = int'($urandom_range(0, 1150)) - 100;
        dl   = dr + int'($urandom_range(0, 160)) - 80;
        if ($urandom_range(0, 1) == 1) begin
            b = brake_lvl + int'($urandom_range(0, 400)) - 200;
        end else begin
            b = $urandom_range(0, 1500);
        end
        smp.apps_right   = clamp_adc(R_OFFSET + dr);
        smp.apps_left    = clamp_adc(L_OFFSET + dl);
        smp.brake_sensor = clamp_adc(b);
        case ($urandom_range(0, 3))
            0:       rpm = $urandom_range(0, RPM_FULL);
            1:       rpm = speed_cap + int'($urandom_range(0, 40)) - 20;
            2:       rpm = $urandom_range(0, 15000);
            default: rpm = ($urandom_range(0, 1) == 1) ? 0 : RPM_FULL;
        endcase
        if (rpm < 0) begin
            rpm = 0;
        end else if (rpm > RPM_FULL) begin
            rpm = RPM_FULL;
        end
        smp.motor_rpm = rpm[RPM_W-1:0];
        if (kind >= 65 && kind < 85) begin
            case ($urandom_range(0, 3))
                0: smp.apps_right   = boundary_value();
                1: smp.apps_left    = boundary_value();
                2: smp.brake_sensor = boundary_value();
                default: begin
                    // Sensor disagreement at the allowed limit or one step either side of it.
                    dl = mismatch_lim + int'($urandom_range(0, 2)) - 1;
                    dl = ($urandom_range(0, 1) == 1) ? dr + dl : dr - dl;
                    smp.apps_left = clamp_adc(L_OFFSET + dl);
                end
            endcase
        end else if (kind >= 85) begin
            smp.apps_right   = ADC_W'($urandom_range(0, ADC_FULL));
            smp.apps_left    = ADC_W'($urandom_range(0, ADC_FULL));
            smp.brake_sensor = ADC_W'($urandom_range(0, ADC_FULL));
            smp.motor_rpm    = RPM_W'($urandom_range(0, RPM_FULL));
        end
        return smp;
    endfunction

    task automatic push_sample(input int r, input int l, input int b, input int rpm);
        t_pedal_sample smp;
        smp.apps_right   = r[ADC_W-1:0];
        smp.apps_left    = l[ADC_W-1:0];
        smp.brake_sensor = b[ADC_W-1:0];
        smp.motor_rpm    = rpm[RPM_W-1:0];
        pending_samples.push_back(smp);
    endtask

    // One register write; the shadow copy follows the same truncation and
    // sign extension as the hardware register.
    task automatic reg_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        case (idx)
            CFG_BRAKE_ACTIVE:    brake_lvl    = data[LEVEL_W-1:0];
            CFG_THROTTLE_ACTIVE: throttle_lvl = $signed(data[LEVEL_W-1:0]);
            CFG_LATCH_RELEASE:   release_lvl  = $signed(data[LEVEL_W-1:0]);
            CFG_MISMATCH_LIMIT:  mismatch_lim = data[LEVEL_W-1:0];
            CFG_DISCONNECT:      disc_lvl     = data[LEVEL_W-1:0];
            CFG_SPEED_CAP:       speed_cap    = data[RPM_W-1:0];
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Twelve-bit levels go out with random junk in the unused upper bits.
    function automatic logic [CFG_DATA_W-1:0] pad_level(int v);
        return {4'($urandom_range(0, 15)), v[LEVEL_W-1:0]};
    endfunction

    task automatic set_levels(input int brk, input int thr, input int rls,
                              input int mis, input int dsc, input int spd);
        reg_write(CFG_BRAKE_ACTIVE, pad_level(brk));
        reg_write(CFG_THROTTLE_ACTIVE, pad_level(thr));
        reg_write(CFG_LATCH_RELEASE, pad_level(rls));
        reg_write(CFG_MISMATCH_LIMIT, pad_level(mis));
        reg_write(CFG_DISCONNECT, pad_level(dsc));
        reg_write(CFG_SPEED_CAP, spd[RPM_W-1:0]);
        @(negedge i_clk);
    endtask

    task automatic set_random_levels();
        set_levels(int'($urandom_range(300, 1500)), int'($urandom_range(0, 800)) - 200,
                   int'($urandom_range(0, 600)) - 200, $urandom_range(50, 2500),
                   $urandom_range(3800, ADC_FULL), $urandom_range(1, 30000));
    endtask

    // Returns once every queued sample has been taken and every expected
    // command has come back; the block is then idle.
    task automatic wait_idle();
        while (pending_samples.size() != 0 || sample_ch.valid ||
               expected_cmds.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    task automatic run_random(input int count);
        repeat (count) begin
            pending_samples.push_back(draw_sample());
        end
        wait_idle();
    endtask

    task automatic set_idling(input int snd, input int rcv);
        snd_idle_pct = snd;
        rcv_idle_pct = rcv;
    endtask

    task automatic compare_field(input string name, input logic [15:0] want,
                                 input logic [15:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            errors++;
        end
    endtask

    // ------------------------------------------------------------------------
    // Sample driver. On each accepted transaction the command is predicted
    // from the payload that was on the channel; then the next sample goes
    // out unless the sender decides to idle this cycle. Valid stays high on
    // an offered sample until it is taken.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : sample_driver
        t_pedal_sample offered;
        t_pedal_sample nxt;
        if (!i_rst_n) begin
            sample_ch.valid <= 1'b0;
        end else begin
            if (sample_ch.valid && sample_ch.ready) begin
                offered.apps_right   = sample_ch.apps_right;
                offered.apps_left    = sample_ch.apps_left;
                offered.brake_sensor = sample_ch.brake_sensor;
                offered.motor_rpm    = sample_ch.motor_rpm;
                expected_cmds.push_back(predict_command(offered));
            end
            if (!sample_ch.valid || sample_ch.ready) begin
                if (pending_samples.size() != 0 &&
                    $urandom_range(0, 99) >= snd_idle_pct) begin
                    nxt = pending_samples.pop_front();
                    sample_ch.valid        <= 1'b1;
                    sample_ch.apps_right   <= nxt.apps_right;
                    sample_ch.apps_left    <= nxt.apps_left;
                    sample_ch.brake_sensor <= nxt.brake_sensor;
                    sample_ch.motor_rpm    <= nxt.motor_rpm;
                end else begin
                    sample_ch.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result monitor. Each accepted transaction is checked against the
    // oldest prediction. Ready is stalled at random, or held low for a long
    // stretch when a hold-off is requested, which backs the block up until
    // it refuses new samples.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : result_monitor
        t_torque_result want;
        if (!i_rst_n) begin
            result_ch.ready <= 1'b0;
        end else begin
            if (result_ch.valid && result_ch.ready) begin
                if (expected_cmds.size() == 0) begin
                    $display("%0t: unexpected transaction, expected none, actual %0d/%0d/%0d/%0d",
                             $time, result_ch.torque, result_ch.status, result_ch.fault,
                             result_ch.implausible_latched);
                    errors++;
                end else begin
                    want = expected_cmds.pop_front();
                    compare_field("torque", want.torque, result_ch.torque);
                    compare_field("status", want.status, result_ch.status);
                    compare_field("fault", want.fault, result_ch.fault);
                    compare_field("latched", want.latched, result_ch.implausible_latched);
                end
            end
            if (hold_gen != hold_ack) begin
                hold_ack  = hold_gen;
                hold_left = HOLD_OFF_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                result_ch.ready <= 1'b0;
            end else begin
                result_ch.ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
            end
        end
    end

    // Watchdog: ends a run that hangs.
    initial begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("Some tests failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Test sequence.
    // ------------------------------------------------------------------------
    initial begin
        i_rst_n                = 1'b0;
        i_cfg_we               = 1'b0;
        i_cfg_idx              = '0;
        i_cfg_data             = '0;
        sample_ch.valid        = 1'b0;
        sample_ch.apps_right   = '0;
        sample_ch.apps_left    = '0;
        sample_ch.brake_sensor = '0;
        sample_ch.motor_rpm    = '0;
        result_ch.ready        = 1'b0;
        brake_lvl              = RST_BRAKE_ACTIVE;
        throttle_lvl           = RST_THROTTLE_ACTIVE;
        release_lvl            = RST_LATCH_RELEASE;
        mismatch_lim           = RST_MISMATCH_LIMIT;
        disc_lvl               = RST_DISCONNECT;
        speed_cap              = RST_SPEED_CAP;
        latch_model            = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Sender idles little, receiver a lot.
        set_idling(12, 75);

        // Directed samples at the reset levels.
        push_sample(1600, 2900, 0, 0);        // pedal at rest
        push_sample(2600, 3800, 0, 1000);     // full travel gives full torque
        push_sample(3000, 3950, 100, 1000);   // past full travel, clamped
        push_sample(1400, 2700, 0, 0);        // negative pedal value
        push_sample(2100, 3350, 0, 9000);     // half pedal, power cap at threshold
        push_sample(2100, 3350, 0, 65535);    // power cap at top speed
        push_sample(2100, 3350, 0, 8999);     // one below the cap threshold
        push_sample(4095, 2900, 0, 0);        // right wire broken
        push_sample(1600, 4051, 0, 0);        // left wire broken
        push_sample(1600, 2900, 4051, 0);     // brake wire broken
        push_sample(3600, 2900, 0, 0);        // disagreement exactly at the limit
        push_sample(3601, 2900, 0, 0);        // one past the limit
        push_sample(500, 1900, 0, 0);         // lowest legal reading
        push_sample(499, 1900, 0, 0);         // right reading too low
        push_sample(500, 499, 0, 0);          // left reading too low
        push_sample(3000, 4001, 0, 0);        // left reading too high
        push_sample(1600, 2900, 4001, 0);     // brake reading too high
        push_sample(4000, 4000, 0, 0);        // highest legal readings
        push_sample(1600, 2900, 851, 0);      // braking, no throttle
        push_sample(1600, 2900, 850, 0);      // brake exactly at its level
        push_sample(1901, 3201, 851, 0);      // brake with throttle sets the latch
        push_sample(1900, 3200, 0, 5000);     // normal, but the latch holds torque at 0
        push_sample(1599, 2900, 851, 0);      // pedal rounds to zero, latch releases
        push_sample(1750, 3050, 0, 0);        // normal again with torque
        wait_idle();

        // A throttle level below the release level lets a latch set and clear
        // in one sample. A zero speed threshold must not cap a standing motor.
        // Writes to indexes past the last register change nothing.
        set_levels(RST_BRAKE_ACTIVE, -100, RST_LATCH_RELEASE, RST_MISMATCH_LIMIT,
                   RST_DISCONNECT, 0);
        reg_write(CFG_SPARE_FIRST, '0);
        reg_write(CFG_SPARE_LAST, '1);
        @(negedge i_clk);
        push_sample(1700, 3000, 900, 0);
        push_sample(2100, 3350, 0, 0);
        push_sample(2100, 3350, 0, 1);
        push_sample(2100, 3350, 0, 65535);
        wait_idle();

        // Lowest settings: nearly every reading counts as a broken wire.
        set_levels(0, -2048, -2048, 0, 0, 0);
        run_random(30);

        // Reset levels again, with random samples.
        set_levels(RST_BRAKE_ACTIVE, RST_THROTTLE_ACTIVE, RST_LATCH_RELEASE,
                   RST_MISMATCH_LIMIT, RST_DISCONNECT, RST_SPEED_CAP);
        run_random(100);

        // Sender idles a lot, receiver little.
        set_idling(75, 12);
        set_levels(ADC_FULL, 2047, 2047, ADC_FULL, ADC_FULL, RPM_FULL);
        run_random(30);
        set_random_levels();
        run_random(100);

        // No idling at all. The receiver first holds off for a long stretch
        // while the sender keeps offering, so the block fills and stalls.
        set_idling(0, 0);
        set_random_levels();
        hold_gen++;
        run_random(100);
        set_random_levels();
        run_random(90);

        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+src
src/pptc_pkg.sv
src/pptc_sample_if.sv
src/pptc_result_if.sv
src/pedal_plausibility_torque_command.sv
sim/tb_pedal_plausibility_torque_command.sv
